FILE: hw/rtl/skl_pkg.sv
// ----------------------------------------------------------------------------
// skl_pkg
// Shared constants, codes and controller/datapath types for the sorted key list.
// ----------------------------------------------------------------------------
package skl_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 16;
  localparam int HDL_W    = 16;
  localparam int STATUS_W = 3;
  localparam int ENTRY_W  = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] ADDR_HEAD_KEY = CFG_ADDR_W'(0);

  // operation codes
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE         = 3'd0,
    ST_BELOW_HEAD   = 3'd1,
    ST_DUPLICATE    = 3'd2,
    ST_NOT_FOUND    = 3'd3,
    ST_FULL         = 3'd4,
    ST_HEAD_REFUSED = 3'd5
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture request
    logic compare;  // register per-cell compare flags
    logic ins;      // commit insert shift
    logic del;      // commit delete shift
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic             kind;
    logic             below_head;
    logic             head_match;
    logic             found;
    logic             full;
    logic [CNT_W-1:0] count;
  } dp_sts_t;

endpackage

FILE: hw/rtl/skl_in_if.sv
// ----------------------------------------------------------------------------
// skl_in_if
// Request channel: insert/delete operations with key and record handle.
// ----------------------------------------------------------------------------
interface skl_in_if import skl_pkg::*; ();

  logic             valid;
  logic             ready;
  logic             kind;
  logic [KEY_W-1:0] key;
  logic [HDL_W-1:0] handle;

  modport source (output valid, output kind, output key, output handle, input ready);
  modport sink   (input valid, input kind, input key, input handle, output ready);

endinterface

FILE: hw/rtl/skl_out_if.sv
// ----------------------------------------------------------------------------
// skl_out_if
// Result channel: status code and entry count for each operation.
// ----------------------------------------------------------------------------
interface skl_out_if import skl_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ENTRY_W-1:0]  entry_count;

  modport source (output valid, output status, output entry_count, input ready);
  modport sink   (input valid, input status, input entry_count, output ready);

endinterface

FILE: hw/rtl/skl_datapath.sv
// ----------------------------------------------------------------------------
// skl_datapath
// Row of list cells with parallel key compare and one-slot shift on commit.
// ----------------------------------------------------------------------------
module skl_datapath import skl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [KEY_W-1:0] head_key,
  input  logic             req_kind,
  input  logic [KEY_W-1:0] req_key,
  input  logic [HDL_W-1:0] req_handle,
  input  dp_cmd_t          cmd,
  output dp_sts_t          sts
);

  // request capture
  logic             kind_r;
  logic [KEY_W-1:0] key_r;
  logic [HDL_W-1:0] handle_r;

  // cells
  logic [KEY_W-1:0]    cell_key_r [CAPACITY];
  logic [HDL_W-1:0]    cell_hdl_r [CAPACITY];
  logic [KEY_W-1:0]    cell_key_nxt [CAPACITY];
  logic [HDL_W-1:0]    cell_hdl_nxt [CAPACITY];
  logic [CAPACITY-1:0] cell_vld_r, cell_vld_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  // neighbor views
  logic [KEY_W-1:0]    key_dn [CAPACITY];
  logic [HDL_W-1:0]    hdl_dn [CAPACITY];
  logic [KEY_W-1:0]    key_up [CAPACITY];
  logic [HDL_W-1:0]    hdl_up [CAPACITY];
  logic [CAPACITY-1:0] lt_dn, vld_dn, vld_up;

  // compare flags
  logic [CAPACITY-1:0] lt_now, eq_now;
  logic [CAPACITY-1:0] lt_r;
  logic                below_r, head_eq_r, found_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= req_kind;
      key_r    <= req_key;
      handle_r <= req_handle;
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt_now[i] = cell_vld_r[i] && (cell_key_r[i] < key_r);
      eq_now[i] = cell_vld_r[i] && (cell_key_r[i] == key_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      lt_r      <= lt_now;
      found_r   <= |eq_now;
      below_r   <= key_r < head_key;
      head_eq_r <= key_r == head_key;
    end
  end

  // cell 0 sees the new request below it; the top cell sees an empty slot above
  always_comb begin
    key_dn[0] = key_r;
    hdl_dn[0] = handle_r;
    for (int i = 1; i < CAPACITY; i++) begin
      key_dn[i] = cell_key_r[i-1];
      hdl_dn[i] = cell_hdl_r[i-1];
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      key_up[i] = cell_key_r[i+1];
      hdl_up[i] = cell_hdl_r[i+1];
    end
    key_up[CAPACITY-1] = cell_key_r[CAPACITY-1];
    hdl_up[CAPACITY-1] = cell_hdl_r[CAPACITY-1];
  end

  assign lt_dn  = {lt_r[CAPACITY-2:0], 1'b1};
  assign vld_dn = {cell_vld_r[CAPACITY-2:0], 1'b1};
  assign vld_up = {1'b0, cell_vld_r[CAPACITY-1:1]};

  // keys are strictly sorted, so lt_r is a prefix of ones: cells at or past the
  // insert/delete point shift, the rest hold
  always_comb begin
    cell_vld_nxt = cell_vld_r;
    count_nxt    = count_r;
    for (int i = 0; i < CAPACITY; i++) begin
      cell_key_nxt[i] = cell_key_r[i];
      cell_hdl_nxt[i] = cell_hdl_r[i];
      if (cmd.ins && !lt_r[i]) begin
        cell_key_nxt[i] = lt_dn[i] ? key_r : key_dn[i];
        cell_hdl_nxt[i] = lt_dn[i] ? handle_r : hdl_dn[i];
        cell_vld_nxt[i] = vld_dn[i];
      end else if (cmd.del && !lt_r[i]) begin
        cell_key_nxt[i] = key_up[i];
        cell_hdl_nxt[i] = hdl_up[i];
        cell_vld_nxt[i] = vld_up[i];
      end
    end
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_vld_r <= '0;
      count_r    <= '0;
    end else begin
      cell_vld_r <= cell_vld_nxt;
      count_r    <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_key_r <= cell_key_nxt;
    cell_hdl_r <= cell_hdl_nxt;
  end

  always_comb begin
    sts.kind       = kind_r;
    sts.below_head = below_r;
    sts.head_match = head_eq_r;
    sts.found      = found_r;
    sts.full       = count_r == CNT_W'(CAPACITY);
    sts.count      = count_r;
  end

endmodule

FILE: hw/rtl/skl_ctrl.sv
// ----------------------------------------------------------------------------
// skl_ctrl
// Operation sequencer: capture, compare, decide and commit, result register.
// ----------------------------------------------------------------------------
module skl_ctrl import skl_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output dp_cmd_t             cmd,
  input  dp_sts_t             sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } state_t;

  state_t  state_r;
  logic    out_valid_r;
  status_t status_r;
  status_t status_nxt;
  logic    do_ins, do_del;
  logic    out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    status_nxt = ST_DONE;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    case (sts.kind)
      KIND_INSERT: begin
        if (sts.below_head) begin
          status_nxt = ST_BELOW_HEAD;
        end else if (sts.head_match || sts.found) begin
          status_nxt = ST_DUPLICATE;
        end else if (sts.full) begin
          status_nxt = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      KIND_DELETE: begin
        if (sts.head_match) begin
          status_nxt = ST_HEAD_REFUSED;
        end else if (!sts.found) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          do_del = 1'b1;
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    cmd.load    = in_valid && in_ready;
    cmd.compare = state_r == S_CMP;
    cmd.ins     = (state_r == S_EXEC) && out_free && do_ins;
    cmd.del     = (state_r == S_EXEC) && out_free && do_del;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      status_r    <= ST_DONE;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          // hold the decision until the result register can take it
          if (out_free) begin
            status_r    <= status_nxt;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;

endmodule

FILE: hw/rtl/sorted_key_list_insert_delete.sv
// ----------------------------------------------------------------------------
// sorted_key_list_insert_delete
// Bounded key list sorted by ascending key behind a fixed, configurable head.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one operation per transaction: kind (insert or delete), key
//          and the record handle stored with the key on insert.
//   out_ch returns one transaction per operation: a status code and the number
//          of stored entries after the operation, head excluded.
//   cfg_*  APB write/read of head_key at byte address 0; pready is always high.
// Sequence:
//   an operation is captured when it is accepted, then all cells are compared
//   with its key in a registered compare, then the commit step shifts the cells
//   at or past the insert/delete point by one slot when the operation is carried
//   out and loads the result register; the next operation is accepted after that.
// Stall:
//   the next operation is accepted while a result waits in the output register;
//   its commit holds until that result is taken.
// Reset:
//   rst_n clears the list to empty and head_key to zero; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_key_list_insert_delete import skl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  skl_in_if.sink                in_ch,
  skl_out_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [KEY_W-1:0] head_key_r;
  logic             cfg_wr;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_key_r <= '0;
    end else if (cfg_wr && (cfg_paddr == ADDR_HEAD_KEY)) begin
      head_key_r <= cfg_pwdata[KEY_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr == ADDR_HEAD_KEY) ? CFG_DATA_W'(head_key_r) : '0;

  skl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .cmd        (cmd),
    .sts        (sts)
  );

  skl_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_key   (head_key_r),
    .req_kind   (in_ch.kind),
    .req_key    (in_ch.key),
    .req_handle (in_ch.handle),
    .cmd        (cmd),
    .sts        (sts)
  );

  // count only changes together with a result load
  assign out_ch.entry_count = ENTRY_W'(sts.count);

  // one operation in flight: accept is followed by a busy cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("operation accepted while previous one still in progress");

  // a committed insert grows the list by one
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> (sts.count == $past(sts.count) + CNT_W'(1)))
    else $error("insert commit did not increment entry count");

  // commits never overwrite a result that has not been taken
  a_commit_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ins || cmd.del) |-> (!out_ch.valid || out_ch.ready))
    else $error("commit while result register occupied");

  // the list never grows past its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sts.count <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

endmodule
